@@ rtl/nearest_color_pixel_classifier_defines.svh @@
// Assertion macros for the colour classifier.
`ifndef NEAREST_COLOR_PIXEL_CLASSIFIER_DEFINES_SVH
`define NEAREST_COLOR_PIXEL_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define NCPC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ncpc assertion failed");

// Next-cycle implication, masked during reset.
`define NCPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ncpc assertion failed");

// Next-cycle implication, checked through reset as well.
`define NCPC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("ncpc assertion failed");

`endif

@@ rtl/ncpc_pkg.sv @@
`default_nettype none

package ncpc_pkg;

    localparam int NUM_CLASSES = 4;
    localparam int FRAC_BITS   = 4;
    localparam int CHAN_W      = 8;
    localparam int COORD_W     = CHAN_W + FRAC_BITS;
    localparam int CENTER_W    = 2 * COORD_W;
    localparam int CUTOFF_W    = 13;
    localparam int SQ_W        = 2 * COORD_W;
    localparam int DIST_W      = SQ_W + 1;
    localparam int LIM_SQ_W    = 2 * CUTOFF_W;
    localparam int CLASS_W     = 3;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = CENTER_W;
    localparam int COLOR_W     = 8;
    localparam int CIDX_W      = $clog2(NUM_CLASSES);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CENTER_RED    = 3'd0,
        REG_CENTER_YELLOW = 3'd1,
        REG_CENTER_GREEN  = 3'd2,
        REG_CENTER_BLUE   = 3'd3,
        REG_CUTOFF_RED    = 3'd4,
        REG_CUTOFF_YELLOW = 3'd5,
        REG_CUTOFF_GREEN  = 3'd6,
        REG_CUTOFF_BLUE   = 3'd7
    } cfg_reg_t;

    localparam logic [CLASS_W-1:0] CLASS_NONE = 3'd0;

    localparam logic [CENTER_W-1:0] CENTER_RST [NUM_CLASSES] = '{
        24'd12905725, 24'd11814734, 24'd0, 24'd0
    };
    localparam logic [CUTOFF_W-1:0] CUTOFF_RST [NUM_CLASSES] = '{
        13'd800, 13'd320, 13'd0, 13'd0
    };

    // Representative colours, {B, G, R}
    localparam logic [3*COLOR_W-1:0] REP_BGR [NUM_CLASSES] = '{
        {8'd0,   8'd0,   8'd255},
        {8'd0,   8'd255, 8'd255},
        {8'd0,   8'd255, 8'd0},
        {8'd255, 8'd0,   8'd0}
    };

    typedef struct packed {
        logic [CHAN_W-1:0] chan_a;
        logic [CHAN_W-1:0] chan_b;
    } pixel_in_t;

    typedef struct packed {
        logic [CLASS_W-1:0] class_id;
        logic [COLOR_W-1:0] out_blue;
        logic [COLOR_W-1:0] out_green;
        logic [COLOR_W-1:0] out_red;
    } class_out_t;

endpackage

`default_nettype wire

@@ rtl/nearest_color_pixel_classifier.sv @@
`default_nettype none

// Nearest-colour pixel classifier. Takes the Lab a/b bytes of one pixel per
// transaction and returns the nearest of four configured colour classes whose
// squared a/b distance is strictly below that class's squared cutoff, with
// ties going to the higher class, plus its fixed BGR colour (all zero when no
// class matches). Throughput is one pixel per clock. The pipeline runs from the
// input register through a stage of eight 12x12 squarers, then on to the
// sum/compare/select feeding the output register. Back-pressure stalls the
// whole pipeline. Registers are written through cfg_wr_en/cfg_addr/cfg_wdata;
// the user must write them only while no pixel is in flight, which the block
// does not enforce. The squared cutoffs are registered again from the cutoffs.
module nearest_color_pixel_classifier (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [ncpc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [ncpc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire ncpc_pkg::pixel_in_t               s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output ncpc_pkg::class_out_t                   m_data
);

    localparam int N = ncpc_pkg::NUM_CLASSES;

    logic [ncpc_pkg::CENTER_W-1:0] center_reg [N];
    logic [ncpc_pkg::CUTOFF_W-1:0] cutoff_reg [N];
    logic [ncpc_pkg::LIM_SQ_W-1:0] lim_sq_reg [N];

    logic                       v0_reg, v1_reg, v2_reg;
    logic                       adv0, adv1, adv2;
    ncpc_pkg::pixel_in_t        px_reg;
    logic [ncpc_pkg::SQ_W-1:0]  da2_reg [N];
    logic [ncpc_pkg::SQ_W-1:0]  db2_reg [N];
    logic [ncpc_pkg::SQ_W-1:0]  da2_next [N];
    logic [ncpc_pkg::SQ_W-1:0]  db2_next [N];
    ncpc_pkg::class_out_t       out_reg, out_next;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < N; c++) begin
                center_reg[c] <= ncpc_pkg::CENTER_RST[c];
                cutoff_reg[c] <= ncpc_pkg::CUTOFF_RST[c];
            end
        end else if (cfg_wr_en) begin
            unique case (ncpc_pkg::cfg_reg_t'(cfg_addr))
                ncpc_pkg::REG_CENTER_RED:    center_reg[0] <= cfg_wdata;
                ncpc_pkg::REG_CENTER_YELLOW: center_reg[1] <= cfg_wdata;
                ncpc_pkg::REG_CENTER_GREEN:  center_reg[2] <= cfg_wdata;
                ncpc_pkg::REG_CENTER_BLUE:   center_reg[3] <= cfg_wdata;
                ncpc_pkg::REG_CUTOFF_RED:
                    cutoff_reg[0] <= cfg_wdata[ncpc_pkg::CUTOFF_W-1:0];
                ncpc_pkg::REG_CUTOFF_YELLOW:
                    cutoff_reg[1] <= cfg_wdata[ncpc_pkg::CUTOFF_W-1:0];
                ncpc_pkg::REG_CUTOFF_GREEN:
                    cutoff_reg[2] <= cfg_wdata[ncpc_pkg::CUTOFF_W-1:0];
                ncpc_pkg::REG_CUTOFF_BLUE:
                    cutoff_reg[3] <= cfg_wdata[ncpc_pkg::CUTOFF_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        for (int c = 0; c < N; c++) begin
            lim_sq_reg[c] <= ncpc_pkg::LIM_SQ_W'(cutoff_reg[c]) *
                             ncpc_pkg::LIM_SQ_W'(cutoff_reg[c]);
        end
    end

    // pipeline flow control
    assign adv2    = !v2_reg || m_ready;
    assign adv1    = !v1_reg || adv2;
    assign adv0    = !v0_reg || adv1;
    assign s_ready = adv0;
    assign m_valid = v2_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (adv0) v0_reg <= s_valid;
            if (adv1) v1_reg <= v0_reg;
            if (adv2) v2_reg <= v1_reg;
        end
    end

    // stage 1: per-class squared differences
    always_comb begin
        logic [ncpc_pkg::COORD_W-1:0] pa, pb, ca, cb, da, db;
        pa = {px_reg.chan_a, {ncpc_pkg::FRAC_BITS{1'b0}}};
        pb = {px_reg.chan_b, {ncpc_pkg::FRAC_BITS{1'b0}}};
        for (int c = 0; c < N; c++) begin
            ca = center_reg[c][ncpc_pkg::COORD_W-1:0];
            cb = center_reg[c][ncpc_pkg::CENTER_W-1:ncpc_pkg::COORD_W];
            da = (ca >= pa) ? (ca - pa) : (pa - ca);
            db = (cb >= pb) ? (cb - pb) : (pb - cb);
            da2_next[c] = ncpc_pkg::SQ_W'(da) * ncpc_pkg::SQ_W'(da);
            db2_next[c] = ncpc_pkg::SQ_W'(db) * ncpc_pkg::SQ_W'(db);
        end
    end

    // stage 2: sum, cutoff test, nearest select (later class wins ties)
    always_comb begin
        logic [ncpc_pkg::DIST_W-1:0] d2;
        logic [ncpc_pkg::DIST_W-1:0] best;
        logic [ncpc_pkg::CIDX_W-1:0] win;
        logic                        found;
        best  = '0;
        win   = '0;
        found = 1'b0;
        for (int c = 0; c < N; c++) begin
            d2 = ncpc_pkg::DIST_W'(da2_reg[c]) + ncpc_pkg::DIST_W'(db2_reg[c]);
            if (ncpc_pkg::LIM_SQ_W'(d2) < lim_sq_reg[c]) begin
                if (!found || d2 <= best) begin
                    best  = d2;
                    win   = ncpc_pkg::CIDX_W'(c);
                    found = 1'b1;
                end
            end
        end
        if (found) begin
            out_next.class_id = ncpc_pkg::CLASS_W'(win) + ncpc_pkg::CLASS_W'(1);
            {out_next.out_blue, out_next.out_green, out_next.out_red} =
                ncpc_pkg::REP_BGR[win];
        end else begin
            out_next = '0;
            out_next.class_id = ncpc_pkg::CLASS_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv0) px_reg <= s_data;
        if (adv1) begin
            for (int c = 0; c < N; c++) begin
                da2_reg[c] <= da2_next[c];
                db2_reg[c] <= db2_next[c];
            end
        end
        if (adv2) out_reg <= out_next;
    end

endmodule

`default_nettype wire

@@ rtl/ncpc_checker.sv @@
`default_nettype none

`include "nearest_color_pixel_classifier_defines.svh"

module ncpc_checker (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_valid,
    input wire logic                  s_ready,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire ncpc_pkg::class_out_t  m_data
);

    // a stalled result holds
    `NCPC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // no match carries black, a match carries a known class
    `NCPC_ASSERT_SAME(a_none_black, aclk, aresetn, m_valid && m_data.class_id == ncpc_pkg::CLASS_NONE, m_data.out_blue == 8'd0 && m_data.out_green == 8'd0 && m_data.out_red == 8'd0)
    `NCPC_ASSERT_SAME(a_class_range, aclk, aresetn, m_valid, m_data.class_id <= 3'd4)

    // pipeline empties on reset
    `NCPC_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid)

    // with the output free, input is always taken
    `NCPC_ASSERT_SAME(a_free_ready, aclk, aresetn, !m_valid && s_valid, s_ready)

endmodule

bind nearest_color_pixel_classifier ncpc_checker u_ncpc_checker (.*);

`default_nettype wire
